// ----- sv/cpt_pkg.sv -----
// Shared types and constants for the capture period tachometer.
// No dependencies; imported by cpt_ctrl, cpt_datapath and the top level.
package cpt_pkg;

    // Field widths
    localparam int STAMP_W   = 16;
    localparam int TICK_W    = 10;
    localparam int SPEED_W   = 16;
    localparam int SCALE_W   = 24;
    localparam int LIMIT_W   = 16;
    localparam int IDLE_W    = 17;
    localparam int CFG_IDX_W = 2;
    localparam int TDATA_W   = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIN_PERIOD    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_SCALE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_LIMIT_MS = 2'd2;

    // Configuration reset values
    localparam logic [STAMP_W-1:0] MIN_PERIOD_RST    = 16'd100;
    localparam logic [SCALE_W-1:0] SPEED_SCALE_RST   = 24'd4800000;
    localparam logic [LIMIT_W-1:0] STOP_LIMIT_MS_RST = 16'd1000;

    // Item kinds carried in tuser
    localparam logic FUNC_CAPTURE = 1'b0;
    localparam logic FUNC_TICK    = 1'b1;

    // Saturated speed
    localparam logic [SPEED_W-1:0] SPEED_MAX = 16'hFFFF;

    // Radix-2 divider: one quotient bit per step over the full numerator
    localparam int DIV_STEPS = SCALE_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_STEPS - 1);

    // Controller to datapath commands
    typedef struct packed {
        logic load;       // capture the input item
        logic div_start;  // seed the divider
        logic div_step;   // one restoring divide step
        logic commit;     // update state and load the result register
    } cpt_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic is_tick;    // held item is a time tick
        logic cap_ok;     // held capture period is at or above min_period
        logic out_free;   // result register can take a new result
    } cpt_status_t;

endpackage

// ----- sv/capture_period_tachometer.sv -----
// Channel     Dir  Handshake          Payload
// s_ (items)  in   s_tvalid/s_tready  s_tdata: capture_stamp, tick_ms; s_tuser: func
// m_ (result) out  m_tvalid/m_tready  m_tdata: speed; m_tuser: updated
// cfg_        in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// A capture with an accepted period runs from one transfer to the next through
// the accepting state, a check, 24 steps of the radix-2 divider and a commit.
// A tick or a rejected capture skips the divider; s_tready is high only in idle.
// The commit waits while the result register still holds an untaken result.
// Reset (aresetn, synchronous) restores the register defaults and clears the
// stored stamp, speed and idle timer; no clearing pass. cfg_ready is always high.
//
// Top level; depends on cpt_pkg, cpt_ctrl and cpt_datapath.
module capture_period_tachometer #(
    parameter int COUNTER_BITS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input items
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [cpt_pkg::TDATA_W-1:0]     s_tdata,   // [15:0] capture_stamp, [25:16] tick_ms
    input  logic [0:0]                      s_tuser,   // [0] func
    // results
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [cpt_pkg::SPEED_W-1:0]     m_tdata,   // [15:0] speed
    output logic [0:0]                      m_tuser,   // [0] updated
    // configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [cpt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cpt_pkg::SCALE_W-1:0]     cfg_data
);
    import cpt_pkg::*;

    cpt_cmd_t    cmd;
    cpt_status_t status;

    logic [STAMP_W-1:0] min_period_reg;
    logic [SCALE_W-1:0] speed_scale_reg;
    logic [LIMIT_W-1:0] stop_limit_reg;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_period_reg  <= MIN_PERIOD_RST;
            speed_scale_reg <= SPEED_SCALE_RST;
            stop_limit_reg  <= STOP_LIMIT_MS_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_MIN_PERIOD:    min_period_reg  <= cfg_data[STAMP_W-1:0];
                REG_SPEED_SCALE:   speed_scale_reg <= cfg_data;
                REG_STOP_LIMIT_MS: stop_limit_reg  <= cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    cpt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    cpt_datapath #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .in_func       (s_tuser[0]),
        .in_stamp      (s_tdata[STAMP_W-1:0]),
        .in_tick       (s_tdata[STAMP_W+TICK_W-1:STAMP_W]),
        .min_period    (min_period_reg),
        .speed_scale   (speed_scale_reg),
        .stop_limit_ms (stop_limit_reg),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_speed     (m_tdata),
        .out_updated   (m_tuser[0])
    );

endmodule

// ----- sv/cpt_ctrl.sv -----
// Sequencer for the capture period tachometer.
// Depends on cpt_pkg; drives cpt_datapath through cpt_cmd_t.
module cpt_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  cpt_pkg::cpt_status_t status,
    output cpt_pkg::cpt_cmd_t    cmd
);
    import cpt_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_COMMIT
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // Next state and commands
    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        cmd           = '0;
        in_ready      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (!status.is_tick && status.cap_ok) begin
                    cmd.div_start = 1'b1;
                    cnt_next      = '0;
                    state_next    = ST_DIV;
                end else begin
                    state_next = ST_COMMIT;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                // hold until the result register is free
                if (status.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State and step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ----- sv/cpt_datapath.sv -----
// Datapath of the capture period tachometer: item hold, period, divider,
// speed and idle-timer state, result register. Depends on cpt_pkg.
module cpt_datapath #(
    parameter int COUNTER_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  cpt_pkg::cpt_cmd_t             cmd,
    output cpt_pkg::cpt_status_t          status,
    input  logic                          in_func,
    input  logic [cpt_pkg::STAMP_W-1:0]   in_stamp,
    input  logic [cpt_pkg::TICK_W-1:0]    in_tick,
    input  logic [cpt_pkg::STAMP_W-1:0]   min_period,
    input  logic [cpt_pkg::SCALE_W-1:0]   speed_scale,
    input  logic [cpt_pkg::LIMIT_W-1:0]   stop_limit_ms,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [cpt_pkg::SPEED_W-1:0]   out_speed,
    output logic                          out_updated
);
    import cpt_pkg::*;

    localparam int PW    = COUNTER_BITS + 1;   // period, including the full wrap
    localparam int CMP_W = 34;                 // common width for the period compare
    localparam int SUM_W = IDLE_W + 1;

    // Held item
    logic                    func_reg;
    logic [STAMP_W-1:0]      stamp_reg;
    logic [TICK_W-1:0]       tick_reg;

    // Block state
    logic [COUNTER_BITS-1:0] last_stamp_reg, last_stamp_next;
    logic [SPEED_W-1:0]      speed_reg, speed_next;
    logic [IDLE_W-1:0]       idle_reg, idle_next;

    // Divider
    logic [PW-1:0]           rem_reg;
    logic [SCALE_W-1:0]      dvd_reg;

    // Result register
    logic                    out_valid_reg;
    logic [SPEED_W-1:0]      out_speed_reg;
    logic                    out_updated_reg;
    logic                    changed;

    // Period from the held stamp, masked to the counter width
    logic [31:0]             stamp_wide;
    logic [COUNTER_BITS-1:0] stamp_cnt;
    logic [COUNTER_BITS-1:0] diff;
    logic [PW-1:0]           period;
    logic                    cap_ok;

    assign stamp_wide = {{(32 - STAMP_W){1'b0}}, stamp_reg};
    assign stamp_cnt  = stamp_wide[COUNTER_BITS-1:0];
    assign diff       = stamp_cnt - last_stamp_reg;
    // equal stamps count as one full wrap
    assign period     = (diff == '0) ? {1'b1, {COUNTER_BITS{1'b0}}} : {1'b0, diff};
    assign cap_ok     = CMP_W'(period) >= CMP_W'(min_period);

    // Restoring divide step
    logic [PW:0]   trial;
    logic [PW:0]   trial_sub;
    logic          trial_ge;

    assign trial     = {rem_reg, dvd_reg[SCALE_W-1]};
    assign trial_sub = trial - {1'b0, period};
    assign trial_ge  = trial >= {1'b0, period};

    // Saturated quotient
    logic [SPEED_W-1:0] quot_sat;
    assign quot_sat = (|dvd_reg[SCALE_W-1:SPEED_W]) ? SPEED_MAX : dvd_reg[SPEED_W-1:0];

    // Idle timer advance
    logic [SUM_W-1:0] idle_sum;
    logic             stop_hit;
    assign idle_sum = {1'b0, idle_reg} + SUM_W'(tick_reg);
    assign stop_hit = idle_sum >= SUM_W'(stop_limit_ms);

    // State update on commit
    always_comb begin
        last_stamp_next = last_stamp_reg;
        speed_next      = speed_reg;
        idle_next       = idle_reg;
        changed         = 1'b0;
        if (func_reg == FUNC_TICK) begin
            if (stop_hit) begin
                speed_next = '0;
                idle_next  = '0;
                changed    = 1'b1;
            end else begin
                idle_next = idle_sum[IDLE_W-1:0];
            end
        end else if (cap_ok) begin
            speed_next      = quot_sat;
            last_stamp_next = stamp_cnt;
            idle_next       = '0;
            changed         = 1'b1;
        end
    end

    // Hold the item
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg  <= in_func;
            stamp_reg <= in_stamp;
            tick_reg  <= in_tick;
        end
    end

    // Advance the divider
    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            rem_reg <= '0;
            dvd_reg <= speed_scale;
        end else if (cmd.div_step) begin
            rem_reg <= trial_ge ? trial_sub[PW-1:0] : trial[PW-1:0];
            dvd_reg <= {dvd_reg[SCALE_W-2:0], trial_ge};
        end
    end

    // Block state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_stamp_reg <= '0;
            speed_reg      <= '0;
            idle_reg       <= '0;
        end else if (cmd.commit) begin
            last_stamp_reg <= last_stamp_next;
            speed_reg      <= speed_next;
            idle_reg       <= idle_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_speed_reg   <= speed_next;
            out_updated_reg <= changed;
        end
    end

    assign status.is_tick  = (func_reg == FUNC_TICK);
    assign status.cap_ok   = cap_ok;
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign out_speed   = out_speed_reg;
    assign out_updated = out_updated_reg;

    // Commands never overlap
    a_cmd_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load, cmd.div_start, cmd.div_step, cmd.commit}))
        else $error("overlapping datapath commands");

    // Commit only into a free result register
    a_commit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> (!out_valid_reg || out_ready))
        else $error("commit would overwrite a pending result");

    // A commit always presents a result
    a_commit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> out_valid_reg)
        else $error("result lost after commit");

    // A plain tick or a rejected capture leaves the speed alone
    a_speed_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && !changed) |=> (out_speed_reg == $past(speed_reg)))
        else $error("speed changed without an update");

endmodule
